// File: hw/rtl/rsp_pkg.sv
`default_nettype none
package rsp_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] KIND_INTEGER  = 3'd0;
	localparam logic [2:0] KIND_SIMPLE   = 3'd1;
	localparam logic [2:0] KIND_ERROR    = 3'd2;
	localparam logic [2:0] KIND_BULK     = 3'd3;
	localparam logic [2:0] KIND_STR_END  = 3'd4;
	localparam logic [2:0] KIND_NIL      = 3'd5;
	localparam logic [2:0] KIND_ARRAY    = 3'd6;
	localparam logic [2:0] KIND_PROTO_ERR = 3'd7;

	localparam logic [7:0] CR_BYTE = 8'h0D;

	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         data;
		logic signed [63:0] number;
		logic [3:0]         level;
		logic               done;
	} token_t;

endpackage
`default_nettype wire

// File: hw/rtl/rsp_front.sv
`default_nettype none
module rsp_front
	import rsp_pkg::*;
#(
	parameter int MAX_DEPTH   = 8,
	parameter int LENGTH_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire logic [7:0] in_byte,
	output token_t          tok,
	output logic            tok_valid
);

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	localparam logic [2:0] PH_TYPE      = 3'd0;
	localparam logic [2:0] PH_NUMBER    = 3'd1;
	localparam logic [2:0] PH_TEXT      = 3'd2;
	localparam logic [2:0] PH_SKIP_TYPE = 3'd3;
	localparam logic [2:0] PH_SKIP_BULK = 3'd4;
	localparam logic [2:0] PH_BULK      = 3'd5;
	localparam logic [2:0] PH_TRAIL1    = 3'd6;
	localparam logic [2:0] PH_TRAIL2    = 3'd7;

	logic [2:0]             phase_q, phase_d;
	logic [2:0]             kind_q, kind_d;
	logic [63:0]            acc_q, acc_d;
	logic                   neg_q, neg_d;
	logic                   seen_q, seen_d;
	logic [LENGTH_BITS-1:0] bulk_q, bulk_d;
	logic [DW-1:0]          depth_q, depth_d;
	logic                   err_q, err_d;
	logic [LENGTH_BITS-1:0] cnt_q [MAX_DEPTH];

	logic                   cnt_we;
	logic [IW-1:0]          cnt_idx;
	logic [LENGTH_BITS-1:0] cnt_wd;

	logic [DW-1:0]          fin_depth;
	logic                   fin_done;
	logic [3:0]             digit;
	logic [67:0]            prod;
	logic [67:0]            lim;
	logic                   is_digit;
	logic                   too_long;

	// Pop cascade: find the highest open array that is not on its last element.
	always_comb begin
		fin_depth = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if (DW'(i) < depth_q && cnt_q[i] != LENGTH_BITS'(1))
				fin_depth = DW'(i + 1);
		end
		fin_done = (fin_depth == '0);
	end

	assign digit    = 4'(in_byte - 8'h30);
	assign is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
	assign prod     = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, digit};
	assign lim      = neg_q ? 68'h8000_0000_0000_0000 : 68'h7FFF_FFFF_FFFF_FFFF;
	assign too_long = (acc_q >> LENGTH_BITS) != 64'd0;

	always_comb begin
		phase_d   = phase_q;
		kind_d    = kind_q;
		acc_d     = acc_q;
		neg_d     = neg_q;
		seen_d    = seen_q;
		bulk_d    = bulk_q;
		depth_d   = depth_q;
		err_d     = err_q;
		cnt_we    = 1'b0;
		cnt_idx   = IW'(fin_depth - DW'(1));
		cnt_wd    = cnt_q[IW'(fin_depth - DW'(1))] - LENGTH_BITS'(1);
		tok_valid = 1'b0;
		tok       = '{kind: KIND_PROTO_ERR, data: 8'd0, number: 64'sd0,
			level: 4'd0, done: 1'b0};

		if (err_q) begin
			tok_valid = 1'b1;
		end else begin
			unique case (phase_q)
				PH_TYPE: begin
					acc_d  = 64'd0;
					neg_d  = 1'b0;
					seen_d = 1'b0;
					unique case (in_byte)
						8'h2B: begin kind_d = KIND_SIMPLE; phase_d = PH_TEXT; end
						8'h2D: begin kind_d = KIND_ERROR; phase_d = PH_TEXT; end
						8'h3A: begin kind_d = KIND_INTEGER; phase_d = PH_NUMBER; end
						8'h24: begin kind_d = KIND_BULK; phase_d = PH_NUMBER; end
						8'h2A: begin kind_d = KIND_ARRAY; phase_d = PH_NUMBER; end
						default: begin
							err_d = 1'b1; tok_valid = 1'b1;
						end
					endcase
				end
				PH_NUMBER: begin
					if (in_byte == CR_BYTE) begin
						phase_d = PH_SKIP_TYPE;
						if (!seen_q) begin
							err_d = 1'b1; tok_valid = 1'b1;
						end else if (kind_q == KIND_INTEGER) begin
							tok_valid  = 1'b1;
							tok.kind   = KIND_INTEGER;
							tok.number = neg_q ? -$signed(acc_q) : $signed(acc_q);
							tok.level  = 4'(depth_q);
							tok.done   = fin_done;
							depth_d    = fin_depth;
							cnt_we     = !fin_done;
						end else if (kind_q == KIND_BULK) begin
							if (neg_q && acc_q != 64'd0) begin
								tok_valid = 1'b1;
								tok.kind  = KIND_NIL;
								tok.level = 4'(depth_q);
								tok.done  = fin_done;
								depth_d   = fin_depth;
								cnt_we    = !fin_done;
							end else if (too_long) begin
								err_d = 1'b1; tok_valid = 1'b1;
							end else begin
								bulk_d  = acc_q[LENGTH_BITS-1:0];
								phase_d = PH_SKIP_BULK;
							end
						end else begin
							if ((neg_q && acc_q != 64'd0) || acc_q == 64'd0) begin
								// empty array counts as a finished element
								tok_valid = 1'b1;
								tok.kind  = KIND_ARRAY;
								tok.level = 4'(depth_q);
								tok.done  = fin_done;
								depth_d   = fin_depth;
								cnt_we    = !fin_done;
							end else if (too_long || depth_q >= DW'(MAX_DEPTH)) begin
								err_d = 1'b1; tok_valid = 1'b1;
							end else begin
								tok_valid  = 1'b1;
								tok.kind   = KIND_ARRAY;
								tok.number = $signed(acc_q);
								tok.level  = 4'(depth_q);
								cnt_we     = 1'b1;
								cnt_idx    = IW'(depth_q);
								cnt_wd     = acc_q[LENGTH_BITS-1:0];
								depth_d    = depth_q + DW'(1);
							end
						end
					end else if (in_byte == 8'h2D && !seen_q && !neg_q) begin
						neg_d = 1'b1;
					end else if (is_digit && prod <= lim) begin
						acc_d  = prod[63:0];
						seen_d = 1'b1;
					end else begin
						err_d = 1'b1; tok_valid = 1'b1;
					end
				end
				PH_TEXT: begin
					tok_valid = 1'b1;
					if (in_byte == CR_BYTE) begin
						phase_d   = PH_SKIP_TYPE;
						tok.kind  = KIND_STR_END;
						tok.level = 4'(depth_q);
						tok.done  = fin_done;
						depth_d   = fin_depth;
						cnt_we    = !fin_done;
					end else begin
						tok.kind  = kind_q;
						tok.data  = in_byte;
						tok.level = 4'(depth_q);
					end
				end
				PH_SKIP_TYPE: phase_d = PH_TYPE;
				PH_SKIP_BULK: phase_d = (bulk_q != '0) ? PH_BULK : PH_TRAIL1;
				PH_BULK: begin
					tok_valid = 1'b1;
					tok.kind  = KIND_BULK;
					tok.data  = in_byte;
					tok.level = 4'(depth_q);
					if (bulk_q != '0)
						bulk_d = bulk_q - LENGTH_BITS'(1);
					if (bulk_q <= LENGTH_BITS'(1))
						phase_d = PH_TRAIL1;
				end
				PH_TRAIL1: begin
					phase_d   = PH_TRAIL2;
					tok_valid = 1'b1;
					tok.kind  = KIND_STR_END;
					tok.level = 4'(depth_q);
					tok.done  = fin_done;
					depth_d   = fin_depth;
					cnt_we    = !fin_done;
				end
				PH_TRAIL2: phase_d = PH_TYPE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			kind_q  <= KIND_INTEGER;
			acc_q   <= 64'd0;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			bulk_q  <= '0;
			depth_q <= '0;
			err_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			seen_q  <= seen_d;
			bulk_q  <= bulk_d;
			depth_q <= depth_d;
			err_q   <= err_d;
		end
	end

	// element counts: written only on push or count-off
	always_ff @(posedge clk) begin
		if (accept && cnt_we)
			cnt_q[cnt_idx] <= cnt_wd;
	end

endmodule
`default_nettype wire

// File: hw/rtl/rsp_queue.sv
`default_nettype none
module rsp_queue
	import rsp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  token_t    push_tok,
	output logic      has_room,
	output logic      head_valid,
	output token_t    head_tok,
	input  wire logic pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	token_t          mem [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [PW:0]     fill_q;
	logic            do_pop;

	assign has_room   = fill_q != (PW+1)'(QUEUE_DEPTH);
	assign head_valid = fill_q != '0;
	assign head_tok   = mem[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + PW'(1);
			if (do_pop)
				rd_q <= rd_q + PW'(1);
			fill_q <= fill_q + (PW+1)'(push) - (PW+1)'(do_pop);
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/resp_stream_parser_core.sv
// RESP2 byte-stream tokenizer.
// Input channel s_*: one protocol byte per item in s_tdata[7:0].
// Output channel m_*: one token per item; m_tuser carries the token kind,
// m_tdata carries the byte, the number, the nest level and the done flag.
// A byte gives at most one token; type bytes, number digits and skipped
// line ends give none.
// Throughput: one byte per cycle while the token queue has room. The parser
// front resolves the whole byte, including the array pop cascade, in the
// cycle it is accepted.
// Token path: each token is written into a four-entry queue when its byte is
// taken, and m_tvalid is driven straight from the queue head.
// Reset: clears the parser, the nesting depth, the sticky error flag and the
// queue; the element count store holds no reset.
// Stall: when the receiver holds m_tready low the queue fills and s_tready
// drops once four tokens are waiting; the parser then holds its state.
// After a protocol error every further byte gives an error token until reset.
`default_nettype none
module resp_stream_parser_core
	import rsp_pkg::*;
#(
	parameter int MAX_DEPTH   = 8,
	parameter int LENGTH_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // [7:0] token_byte, [71:8] number_value,
	                                    // [75:72] nest_level, [76] value_done, rest zero
	output logic [2:0]       m_tuser    // [2:0] token_kind
);

	logic   accept;
	logic   tok_valid;
	token_t tok;
	token_t head;

	assign accept = s_tvalid && s_tready;

	// front: classify each byte and update the parse state
	rsp_front #(
		.MAX_DEPTH  (MAX_DEPTH),
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (s_tdata),
		.tok      (tok),
		.tok_valid(tok_valid)
	);

	// back: hold tokens until the receiver takes them
	rsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && tok_valid),
		.push_tok  (tok),
		.has_room  (s_tready),
		.head_valid(m_tvalid),
		.head_tok  (head),
		.pop       (m_tready)
	);

	assign m_tuser = head.kind;
	assign m_tdata = {3'd0, head.done, head.level, head.number, head.data};

endmodule
`default_nettype wire

// File: hw/rtl/rsp_checker.sv
`default_nettype none
module rsp_checker
	import rsp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [79:0] m_tdata,
	input wire logic [2:0]  m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("token dropped while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_PROTO_ERR |-> m_tdata == 80'd0)
		else $error("error token carries data");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !(m_tuser == KIND_SIMPLE || m_tuser == KIND_ERROR ||
		m_tuser == KIND_BULK) |-> m_tdata[7:0] == 8'd0)
		else $error("byte set on non-byte token");

	a_num_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !(m_tuser == KIND_INTEGER || m_tuser == KIND_ARRAY)
		|-> m_tdata[71:8] == 64'd0)
		else $error("number set on non-number token");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[79:77] == 3'd0)
		else $error("padding bits set");

endmodule

bind resp_stream_parser_core rsp_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
// Self-checking bench for the RESP2 tokenizer: a byte-level predictor follows
// each accepted byte and queues the token it should give; every token taken
// from the output is compared field by field against the oldest one queued.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rsp_pkg::*;

	localparam int DEPTH_LIMIT = 8;
	localparam logic [63:0] LEN_LIMIT = 64'hFFFF_FFFF;
	localparam logic [7:0] LF_BYTE = 8'h0A;

	typedef enum logic [2:0] {
		PH_TYPE, PH_NUMBER, PH_TEXT, PH_SKIP_TO_TYPE,
		PH_SKIP_TO_BULK, PH_BULK, PH_TRAIL1, PH_TRAIL2
	} phase_e;

	// Predicts tokens from accepted bytes and checks the tokens that come out.
	class token_scoreboard;
		phase_e      phase;
		logic [2:0]  item;
		logic [63:0] accum;
		bit          negative;
		bit          digit_seen;
		logic [63:0] bulk_left;
		int unsigned depth;
		logic [63:0] counts [DEPTH_LIMIT];
		bit          latched;
		token_t      waiting [$];
		int          mismatches;
		int          tokens;

		function new();
			phase = PH_TYPE;
			item = KIND_INTEGER;
			accum = '0;
			negative = 0;
			digit_seen = 0;
			bulk_left = '0;
			depth = 0;
			latched = 0;
			mismatches = 0;
			tokens = 0;
		endfunction

		function void give(logic [2:0] kind, logic [7:0] data, logic [63:0] num,
				logic [3:0] lvl, bit done);
			token_t t;
			t.kind = kind;
			t.data = data;
			t.number = num;
			t.level = lvl;
			t.done = done;
			waiting.push_back(t);
		endfunction

		function void fail();
			latched = 1;
			give(KIND_PROTO_ERR, 8'd0, 64'd0, 4'd0, 1'b0);
		endfunction

		// Count off one finished element and pop every array it closes.
		function bit close_element();
			while (depth > 0) begin
				if (counts[depth-1] > 0)
					counts[depth-1] = counts[depth-1] - 1;
				if (counts[depth-1] != 0)
					return 1'b0;
				depth--;
			end
			return 1'b1;
		endfunction

		// Level is taken before the pops.
		function void give_closing(logic [2:0] kind, logic [7:0] data, logic [63:0] num);
			logic [3:0] lvl;
			bit done;
			lvl = depth[3:0];
			done = close_element();
			give(kind, data, num, lvl, done);
		endfunction

		function void finish_number();
			logic [63:0] sval;
			if (!digit_seen) begin
				fail();
				return;
			end
			sval = negative ? (64'd0 - accum) : accum;
			phase = PH_SKIP_TO_TYPE;
			if (item == KIND_INTEGER) begin
				give_closing(KIND_INTEGER, 8'd0, sval);
			end else if (item == KIND_BULK) begin
				if (negative && accum != 0)
					give_closing(KIND_NIL, 8'd0, 64'd0);
				else if (accum > LEN_LIMIT)
					fail();
				else begin
					bulk_left = accum;
					phase = PH_SKIP_TO_BULK;
				end
			end else begin
				// negative or zero count: empty array, counts as one element
				if ((negative && accum != 0) || accum == 0)
					give_closing(KIND_ARRAY, 8'd0, 64'd0);
				else if (accum > LEN_LIMIT || depth >= DEPTH_LIMIT)
					fail();
				else begin
					give(KIND_ARRAY, 8'd0, accum, depth[3:0], 1'b0);
					counts[depth] = accum;
					depth++;
				end
			end
		endfunction

		function void start_number(logic [2:0] kind);
			item = kind;
			accum = '0;
			negative = 0;
			digit_seen = 0;
			phase = PH_NUMBER;
		endfunction

		function void note_byte(logic [7:0] b);
			logic [63:0] d;
			logic [63:0] lim;
			if (latched) begin
				fail();
				return;
			end
			case (phase)
				PH_TYPE: begin
					if (b == "+") begin
						item = KIND_SIMPLE;
						phase = PH_TEXT;
					end else if (b == "-") begin
						item = KIND_ERROR;
						phase = PH_TEXT;
					end else if (b == ":")
						start_number(KIND_INTEGER);
					else if (b == "$")
						start_number(KIND_BULK);
					else if (b == "*")
						start_number(KIND_ARRAY);
					else
						fail();
				end
				PH_NUMBER: begin
					if (b == CR_BYTE)
						finish_number();
					else if (b == "-" && !digit_seen && !negative)
						negative = 1;
					else if (b >= "0" && b <= "9") begin
						d = 64'(b - "0");
						lim = negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
						if (accum > (lim - d) / 10)
							fail();
						else begin
							accum = accum * 10 + d;
							digit_seen = 1;
						end
					end else
						fail();
				end
				PH_TEXT: begin
					if (b == CR_BYTE) begin
						phase = PH_SKIP_TO_TYPE;
						give_closing(KIND_STR_END, 8'd0, 64'd0);
					end else
						give(item, b, 64'd0, depth[3:0], 1'b0);
				end
				PH_SKIP_TO_TYPE: phase = PH_TYPE;
				PH_SKIP_TO_BULK: phase = (bulk_left > 0) ? PH_BULK : PH_TRAIL1;
				PH_BULK: begin
					give(KIND_BULK, b, 64'd0, depth[3:0], 1'b0);
					if (bulk_left > 0)
						bulk_left = bulk_left - 1;
					if (bulk_left == 0)
						phase = PH_TRAIL1;
				end
				PH_TRAIL1: begin
					phase = PH_TRAIL2;
					give_closing(KIND_STR_END, 8'd0, 64'd0);
				end
				default: phase = PH_TYPE;
			endcase
		endfunction

		function void check_token(logic [2:0] kind, logic [79:0] data);
			token_t want;
			token_t got;
			got.kind = kind;
			got.data = data[7:0];
			got.number = data[71:8];
			got.level = data[75:72];
			got.done = data[76];
			tokens++;
			if (waiting.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token kind %0d data %h", kind, data);
				return;
			end
			want = waiting.pop_front();
			if (got.kind !== want.kind || got.data !== want.data ||
					got.number !== want.number || got.level !== want.level ||
					got.done !== want.done || data[79:77] !== 3'b000) begin
				mismatches++;
				if (mismatches <= 10)
					$display("token %0d: kind %0d/%0d byte %h/%h num %0d/%0d lvl %0d/%0d done %0d/%0d (exp/act)",
						tokens, want.kind, got.kind, want.data, got.data,
						want.number, got.number, want.level, got.level,
						want.done, got.done);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic [2:0]  m_tuser;

	token_scoreboard tokens_sb;
	logic [7:0] stream [$];
	int send_idle;
	int recv_idle;
	int sent;
	int messages;

	resp_stream_parser_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// Hard stop well beyond the slowest correct run.
	initial begin
		#5ms;
		$display("FAIL resp_stream_parser_core");
		$finish;
	end

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			stream.push_back(s[i]);
	endfunction

	// CR, then a byte the parser skips unchecked: mostly LF, sometimes anything.
	function automatic void push_eol();
		stream.push_back(CR_BYTE);
		stream.push_back(($urandom_range(9) == 0) ? 8'($urandom) : LF_BYTE);
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		b = 8'($urandom);
		return (b == CR_BYTE) ? 8'h0C : b;
	endfunction

	function automatic void push_number(logic [2:0] kind, string digits);
		stream.push_back(kind == KIND_INTEGER ? ":" : (kind == KIND_BULK ? "$" : "*"));
		push_text(digits);
		push_eol();
	endfunction

	function automatic void push_line(logic [7:0] lead, int n);
		stream.push_back(lead);
		repeat (n) stream.push_back(text_byte());
		push_eol();
	endfunction

	function automatic void push_bulk(int n);
		push_number(KIND_BULK, $sformatf("%0d", n));
		repeat (n) stream.push_back(8'($urandom));
		stream.push_back(8'($urandom));
		stream.push_back(8'($urandom));
	endfunction

	function automatic string random_integer();
		longint v;
		case ($urandom_range(5))
			0: v = longint'($urandom_range(9));
			1: v = -longint'($urandom_range(1000));
			2: v = 64'h8000_0000_0000_0000;
			3: v = 64'h7FFF_FFFF_FFFF_FFFF;
			default: v = longint'({$urandom, $urandom});
		endcase
		return $sformatf("%0d", v);
	endfunction

	// One well-formed value, nested arrays thinning out with depth.
	function automatic void push_value(int lvl);
		int pick;
		int n;
		pick = $urandom_range(7);
		if (pick >= 6 && (lvl >= DEPTH_LIMIT || $urandom_range(lvl) > 1))
			pick = $urandom_range(5);
		case (pick)
			0: push_line("+", $urandom_range(6));
			1: push_line("-", $urandom_range(6));
			2: push_number(KIND_INTEGER, random_integer());
			3: push_bulk($urandom_range(6));
			4: push_number(KIND_BULK, $sformatf("-%0d", $urandom_range(1, 3)));
			5: push_number(KIND_ARRAY, ($urandom_range(1)) ? "0" : $sformatf("-%0d", $urandom_range(4)));
			default: begin
				n = $urandom_range(1, 3);
				push_number(KIND_ARRAY, $sformatf("%0d", n));
				repeat (n) push_value(lvl + 1);
			end
		endcase
	endfunction

	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		tokens_sb.note_byte(b);
		sent++;
	endtask

	// Receiver: check each taken token, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tokens_sb.check_token(m_tuser, m_tdata);
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		int total;
		int wait_cycles;
		tokens_sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		m_tready = 1'b0;
		send_idle = 18;
		recv_idle = 66;
		sent = 0;
		messages = 0;

		// Directed: every item type, number extremes, empty and nil forms,
		// a full-depth nest and a bulk of zero length.
		push_text("+OK"); push_eol();
		push_text("-E"); push_eol();
		push_number(KIND_INTEGER, "-9223372036854775808");
		push_number(KIND_INTEGER, "9223372036854775807");
		push_number(KIND_INTEGER, "-0");
		push_bulk(0);
		push_bulk(2);
		push_number(KIND_BULK, "-1");
		push_number(KIND_ARRAY, "-1");
		push_number(KIND_ARRAY, "0");
		repeat (DEPTH_LIMIT) push_number(KIND_ARRAY, "1");
		push_number(KIND_INTEGER, "7");
		messages = 11;

		while (stream.size() < 1400) begin
			push_value(0);
			messages++;
		end

		// A protocol error is sticky until reset, so only one kind fits a run:
		// pick it at random and follow it with some bytes that must all fail.
		case ($urandom_range(6))
			0: stream.push_back(8'($urandom_range(1)) ? CR_BYTE : "x");
			1: push_text(":12a");
			2: push_text(":99999999999999999999");
			3: push_text("$4294967296\r");
			4: repeat (DEPTH_LIMIT + 1) push_number(KIND_ARRAY, "2");
			5: push_text(":\r");
			default: push_text("*-5-\r");
		endcase
		repeat (6) stream.push_back(8'($urandom));
		total = stream.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stream[i]) begin
			if (i == total / 3) begin
				send_idle = 66;
				recv_idle = 18;
			end else if (i == 2 * total / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			send_byte(stream[i]);
		end
		s_tvalid <= 1'b0;

		wait_cycles = 0;
		while (tokens_sb.waiting.size() != 0 && wait_cycles < 10000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (8) @(posedge clk);

		$display("sent %0d bytes in %0d values plus an error tail; checked %0d tokens",
			sent, messages, tokens_sb.tokens);
		$display("mismatches %0d, tokens still awaited %0d",
			tokens_sb.mismatches, tokens_sb.waiting.size());
		if (tokens_sb.mismatches == 0 && tokens_sb.waiting.size() == 0)
			$display("PASS resp_stream_parser_core");
		else
			$display("FAIL resp_stream_parser_core");
		$finish;
	end

endmodule
`default_nettype wire
